// ===== rtl/core/rslc_pkg.sv =====
// shared types and constants for the row scan lane centre block
package rslc_pkg;

    localparam int unsigned ROW_WIDTH_W     = 12;
    localparam int unsigned EDGE_W          = 11;
    localparam int unsigned CENTRE_W        = 11;
    localparam int unsigned RUN_W           = 12;
    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd640;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_MIN   = 12'd2;
    localparam logic [EDGE_W-1:0]      EDGE_MAX        = 11'd2047;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_WIDTH = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NONE  = 2'd1,
        STATUS_NOISE = 2'd2
    } t_row_status;

    typedef struct packed {
        logic pixel_bit;
        logic row_last;
    } t_in_item;

    typedef struct packed {
        logic [EDGE_W-1:0]       line_count;
        logic [EDGE_W-1:0]       edge_count;
        logic [CENTRE_W-1:0]     lane_centre;
        t_row_status             row_status;
        logic                    pair_second;
        logic signed [RUN_W-1:0] centre_run;
    } t_out_item;

endpackage

// ===== rtl/core/row_scan_lane_centre.sv =====
// top level: row scan transition counter and lane centre finder
//
// Input channel: one binary pixel per transaction (i_in_valid / o_in_stall,
// payload i_in_data), row_last marks the final pixel of a row.
// Output channel: one result per row (o_out_valid / i_out_stall, payload
// o_out_data): line and transition counts, lane centre, status, pair flag
// and centre run between the two rows of a pair.
// Config: APB-style port, row_width at byte address 0, read back on prdata.
// A row_last transaction passes the input register, then one compare/add
// stage into the result register, before its result shows. Throughput: one
// pixel per clock while the output is not stalled, set by the update of the
// edge counter and stripe registers on every accepted pixel.
// Reset (synchronous, active low) empties both registers, clears all row
// and pair state and sets row_width to 640.
// While the output is stalled with a result held, the input register holds
// its pixel and o_in_stall rises once that register is full.
module row_scan_lane_centre #(
    parameter int unsigned MAX_ROW_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rslc_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rslc_pkg::t_out_item               o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rslc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rslc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rslc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int unsigned CW = $clog2(MAX_ROW_WIDTH);
    localparam int unsigned LW = (CW + 1 > rslc_pkg::ROW_WIDTH_W) ?
                                 CW + 1 : rslc_pkg::ROW_WIDTH_W;
    localparam int unsigned RW = (CW > rslc_pkg::RUN_W) ? CW : rslc_pkg::RUN_W;
    localparam logic [CW-1:0] COL_LAST  = CW'(MAX_ROW_WIDTH - 1);
    localparam logic [LW-1:0] WIDTH_MAX = LW'(MAX_ROW_WIDTH);

    logic [rslc_pkg::ROW_WIDTH_W-1:0] r_row_width;

    logic                 r_in_valid;
    rslc_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    rslc_pkg::t_out_item  r_out;

    logic                          r_prev;
    logic [CW-1:0]                 r_col;
    logic [rslc_pkg::EDGE_W-1:0]   r_edges;
    logic [CW-1:0]                 r_start;
    logic [CW-1:0]                 r_one;
    logic [CW-1:0]                 r_two;
    logic [CW-1:0]                 r_held;
    logic [CW-1:0]                 r_first;
    logic                          r_phase;

    logic                          n_prev;
    logic [CW-1:0]                 n_col;
    logic [rslc_pkg::EDGE_W-1:0]   n_edges;
    logic [CW-1:0]                 n_start;
    logic [CW-1:0]                 n_one;
    logic [CW-1:0]                 n_two;
    logic [CW-1:0]                 n_held;
    logic [CW-1:0]                 n_first;
    logic                          n_phase;
    rslc_pkg::t_out_item           n_out;

    logic                          advance;
    logic                          step;
    logic                          is_edge;
    logic [CW:0]                   stripe_sum;
    logic [CW-1:0]                 stripe_mid;
    logic [rslc_pkg::EDGE_W:0]     lines_sum;
    logic [rslc_pkg::EDGE_W-1:0]   lines;
    logic [LW-1:0]                 width_use;
    logic [CW-1:0]                 single_c;
    logic [LW-1:0]                 mirror_sum;
    logic [CW-1:0]                 centre_one;
    logic [CW:0]                   pair_sum;
    logic [CW-1:0]                 centre_two;
    logic [CW-1:0]                 centre;
    rslc_pkg::t_row_status         status;
    logic [RW-1:0]                 run_diff;

    // handshake
    assign advance     = !(r_out_valid && i_out_stall);
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config port
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == rslc_pkg::REG_ROW_WIDTH) begin
            prdata = rslc_pkg::APB_DATA_W'(r_row_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= rslc_pkg::ROW_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == rslc_pkg::REG_ROW_WIDTH) begin
            r_row_width <= pwdata[rslc_pkg::ROW_WIDTH_W-1:0];
        end
    end

    // per-pixel update
    always_comb begin
        is_edge    = (r_col != '0) && (r_in.pixel_bit != r_prev);
        stripe_sum = {1'b0, r_start} + {1'b0, r_col};
        stripe_mid = stripe_sum[CW:1];

        n_prev  = r_in.pixel_bit;
        n_col   = (r_col != COL_LAST) ? r_col + 1'b1 : r_col;
        n_edges = r_edges;
        n_start = r_start;
        n_one   = r_one;
        n_two   = r_two;

        if (is_edge) begin
            case (r_edges)
                11'd0: begin
                    n_start = r_col;
                    n_one   = r_col;
                end
                11'd1: begin
                    n_one = stripe_mid;
                end
                11'd2: begin
                    n_start = r_col;
                    n_two   = r_col;
                end
                11'd3: begin
                    n_two = stripe_mid;
                end
                default: begin
                end
            endcase
            if (r_edges != rslc_pkg::EDGE_MAX) begin
                n_edges = r_edges + 1'b1;
            end
        end
    end

    // row end evaluation
    always_comb begin
        lines_sum = {1'b0, n_edges} + 1'b1;
        lines     = lines_sum[rslc_pkg::EDGE_W:1];

        width_use = LW'(r_row_width);
        if (width_use < LW'(rslc_pkg::ROW_WIDTH_MIN)) begin
            width_use = LW'(rslc_pkg::ROW_WIDTH_MIN);
        end else if (width_use > WIDTH_MAX) begin
            width_use = WIDTH_MAX;
        end

        single_c   = (n_edges >= 11'd2) ? n_one : '0;
        mirror_sum = LW'(single_c) + width_use;
        if (LW'(single_c) >= (width_use >> 1)) begin
            centre_one = single_c >> 1;
        end else begin
            centre_one = CW'(mirror_sum >> 1);
        end

        pair_sum   = {1'b0, n_one} + {1'b0, n_two};
        centre_two = pair_sum[CW:1];

        if (lines == '0) begin
            status = rslc_pkg::STATUS_NONE;
            centre = r_held;
        end else if (lines >= 11'd3) begin
            status = rslc_pkg::STATUS_NOISE;
            centre = r_held;
        end else begin
            status = rslc_pkg::STATUS_OK;
            centre = (lines == 11'd1) ? centre_one : centre_two;
        end

        run_diff = RW'(centre) - RW'(r_first);

        n_held  = centre;
        n_first = r_phase ? r_first : centre;
        n_phase = !r_phase;

        n_out.line_count  = lines;
        n_out.edge_count  = n_edges;
        n_out.lane_centre = rslc_pkg::CENTRE_W'(centre);
        n_out.row_status  = status;
        n_out.pair_second = r_phase;
        n_out.centre_run  = r_phase ? rslc_pkg::RUN_W'(run_diff) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= 1'b0;
            r_col       <= '0;
            r_edges     <= '0;
            r_start     <= '0;
            r_one       <= '0;
            r_two       <= '0;
            r_held      <= '0;
            r_first     <= '0;
            r_phase     <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step && r_in.row_last;
            end
            if (step) begin
                r_prev <= n_prev;
                if (r_in.row_last) begin
                    r_col   <= '0;
                    r_edges <= '0;
                    r_start <= '0;
                    r_one   <= '0;
                    r_two   <= '0;
                    r_first <= n_first;
                    r_phase <= n_phase;
                    if (status == rslc_pkg::STATUS_OK) begin
                        r_held <= n_held;
                    end
                end else begin
                    r_col   <= n_col;
                    r_edges <= n_edges;
                    r_start <= n_start;
                    r_one   <= n_one;
                    r_two   <= n_two;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step && r_in.row_last) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/core/rslc_checker.sv =====
// port-level checker for the row scan lane centre block, with its bind
module rslc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rslc_pkg::t_out_item o_out_data
);

    // a stalled result transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_line_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ({1'b0, o_out_data.line_count} ==
             (({1'b0, o_out_data.edge_count} + 12'd1) >> 1)))
        else $error("line count does not follow edge count");

    a_status_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.row_status == rslc_pkg::STATUS_NONE) ==
             (o_out_data.line_count == 11'd0)))
        else $error("status none disagrees with line count");

    a_run_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pair_second |-> o_out_data.centre_run == 12'sd0)
        else $error("centre run nonzero on first row of pair");

endmodule

bind row_scan_lane_centre rslc_checker u_rslc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
